// File: hdl/cdvf_pkg.sv
// ============================================================================
// cdvf_pkg - shared types and constants for the stereo volume fader
// Field widths, reset and bias constants and the gain lookup used by the fader datapath.
// ============================================================================
package cdvf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int VOL_W    = 12;
    localparam int GAIN_W   = 11;
    localparam int LEVEL_W  = 17;
    // |sample * gain| < 2^26, so 27 bits signed hold every product
    localparam int PROD_W   = 27;
    localparam int GAIN_SHIFT = 10;

    localparam logic [VOL_W-1:0] VOL_RESET = 12'h400;
    localparam logic [PROD_W-1:0] DIV_BIAS = PROD_W'((1 << GAIN_SHIFT) - 1);

    // Coarse steps of 4 from bits 10:2; below 4 the fine bits 1:0 take over.
    // Bit 11 never acts on the gain.
    function automatic logic [GAIN_W-1:0] gain_of(input logic [VOL_W-1:0] vol);
        logic [GAIN_W-1:0] coarse;
        logic [GAIN_W-1:0] fine;
        coarse = {vol[10:2], 2'b00};
        fine   = {9'b0, vol[1:0]};
        return (coarse != '0) ? coarse : fine;
    endfunction

    // Pipeline enables shared by the lanes and the merge stage
    typedef struct packed {
        logic prod_load;   // product registers take a new transaction
        logic out_load;    // output register takes the lane results
    } cdvf_ctrl_t;

endpackage

// File: hdl/cdvf_in_if.sv
// ============================================================================
// cdvf_in_if - sample input channel
// Valid/ready channel carrying one stereo sample pair, target and pause flag.
// ============================================================================
interface cdvf_in_if
    import cdvf_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic        [VOL_W-1:0]    target_volume;
    logic                       audio_paused;

    modport source (output valid, left_sample, right_sample, target_volume,
                    audio_paused, input ready);
    modport sink   (input valid, left_sample, right_sample, target_volume,
                    audio_paused, output ready);
endinterface

// File: hdl/cdvf_out_if.sv
// ============================================================================
// cdvf_out_if - level output channel
// Valid/ready channel carrying one pair of scaled stereo levels.
// ============================================================================
interface cdvf_out_if
    import cdvf_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] left_level;
    logic signed [LEVEL_W-1:0] right_level;

    modport source (output valid, left_level, right_level, input ready);
    modport sink   (input valid, left_level, right_level, output ready);
endinterface

// File: hdl/cdvf_lane.sv
// ============================================================================
// cdvf_lane - one channel of the fader datapath
// Registered sample*gain product, then divide by 1024 toward zero.
// ============================================================================
module cdvf_lane
    import cdvf_pkg::*;
(
    input  logic                       clk,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic        [GAIN_W-1:0]   gain,
    output logic signed [LEVEL_W-1:0]  level
);

    logic signed [SAMPLE_W+GAIN_W:0] prod_full;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [PROD_W-1:0]        prod_next;
    logic        [PROD_W-1:0]        biased;

    assign prod_full = sample * $signed({1'b0, gain});
    assign prod_next = prod_full[PROD_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // bias negatives so the arithmetic shift truncates toward zero
    assign biased = prod_reg[PROD_W-1] ? (prod_reg + DIV_BIAS) : prod_reg;
    assign level  = biased[PROD_W-1:GAIN_SHIFT];

endmodule

// File: hdl/cdvf_merge.sv
// ============================================================================
// cdvf_merge - output register for both lanes
// Joins the left and right lane results into one output transaction.
// ============================================================================
module cdvf_merge
    import cdvf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cdvf_ctrl_t                ctrl,
    input  logic signed [LEVEL_W-1:0] left_lane,
    input  logic signed [LEVEL_W-1:0] right_lane,
    output logic                      out_free,
    cdvf_out_if.source                level_out
);

    logic                      valid_reg;
    logic                      valid_next;
    logic signed [LEVEL_W-1:0] left_reg;
    logic signed [LEVEL_W-1:0] right_reg;

    assign out_free   = !valid_reg || level_out.ready;
    assign valid_next = ctrl.out_load ? 1'b1 : (valid_reg && !level_out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            left_reg  <= left_lane;
            right_reg <= right_lane;
        end
    end

    assign level_out.valid       = valid_reg;
    assign level_out.left_level  = left_reg;
    assign level_out.right_level = right_reg;

endmodule

// File: hdl/cd_audio_volume_fader.sv
// ============================================================================
// cd_audio_volume_fader - stereo volume fader with one-step ramp
// Scales each stereo sample pair by the stored volume, then ramps the volume
// one unit toward the target per transaction that is not paused.
// ============================================================================
//
//  channel     dir  modport   payload
//  ---------   ---  -------   ------------------------------------------------
//  sample_in   in   sink      left_sample, right_sample, target_volume,
//                             audio_paused
//  level_out   out  source    left_level, right_level
//
//  One transaction per cycle sustained while level_out.ready stays high.
//  Flow: the product is registered at acceptance, the output register
//  takes it from the product stage, and level_out.valid rises once the
//  output register is loaded. Two transactions can be held in flight.
//  The volume register updates at acceptance, so back-to-back transactions
//  see the ramp immediately.
//  Reset sets the volume to full scale (1024) and empties the pipeline.
//  A stall on level_out backs up through the product stage to sample_in.ready.
//
module cd_audio_volume_fader
    import cdvf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cdvf_in_if.sink     sample_in,
    cdvf_out_if.source  level_out
);

    logic [VOL_W-1:0]  volume_reg;
    logic [VOL_W-1:0]  volume_next;
    logic              prod_valid_reg;
    logic              prod_valid_next;
    logic              accept;
    logic              out_free;
    logic [GAIN_W-1:0] gain;
    cdvf_ctrl_t        ctrl;

    logic signed [LEVEL_W-1:0] left_lane;
    logic signed [LEVEL_W-1:0] right_lane;

    // Product stage can take a new transaction when it is empty or when its
    // current content moves on to the output register this cycle.
    assign sample_in.ready = !prod_valid_reg || out_free;
    assign accept          = sample_in.valid && sample_in.ready;

    assign ctrl.prod_load = accept;
    assign ctrl.out_load  = prod_valid_reg && out_free;

    assign prod_valid_next = accept ? 1'b1 : (prod_valid_reg && !out_free);

    // Paused: zero gain forces both levels to zero
    assign gain = sample_in.audio_paused ? '0 : gain_of(volume_reg);

    // Ramp one step toward the target after the gain is taken; held on pause
    always_comb
    begin
        volume_next = volume_reg;
        if (accept && !sample_in.audio_paused)
        begin
            if (volume_reg < sample_in.target_volume)
                volume_next = volume_reg + VOL_W'(1);
            else if (volume_reg > sample_in.target_volume)
                volume_next = volume_reg - VOL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg     <= VOL_RESET;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            volume_reg     <= volume_next;
            prod_valid_reg <= prod_valid_next;
        end
    end

    cdvf_lane left_lane_i (
        .clk    (clk),
        .load   (ctrl.prod_load),
        .sample (sample_in.left_sample),
        .gain   (gain),
        .level  (left_lane)
    );

    cdvf_lane right_lane_i (
        .clk    (clk),
        .load   (ctrl.prod_load),
        .sample (sample_in.right_sample),
        .gain   (gain),
        .level  (right_lane)
    );

    cdvf_merge merge_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .left_lane  (left_lane),
        .right_lane (right_lane),
        .out_free   (out_free),
        .level_out  (level_out)
    );

endmodule

// File: verif/level_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// level_checker - scoreboard for the stereo volume fader
// Watches both channels, keeps its own copy of the fader volume, predicts
// the level pair of every accepted sample transaction and compares results.
// ============================================================================
module level_checker
    import cdvf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cdvf_in_if    sample_in,
    cdvf_out_if   level_out,
    output int    fail_count,
    output int    pending
);

    localparam logic [VOL_W-1:0] COARSE_MASK = 12'h7fc;
    localparam logic [VOL_W-1:0] FINE_MASK   = 12'h003;
    localparam int               FULL_SCALE  = 1024;

    typedef struct {
        logic signed [LEVEL_W-1:0] left_level;
        logic signed [LEVEL_W-1:0] right_level;
    } level_pair_t;

    level_pair_t      level_queue[$];
    logic [VOL_W-1:0] fader_volume = VOL_RESET;
    int               mismatches   = 0;
    int               queued       = 0;

    assign fail_count = mismatches;
    assign pending    = queued;

    // sample * gain / 1024, truncated toward zero
    function automatic logic signed [LEVEL_W-1:0] scaled_level(
        input logic signed [SAMPLE_W-1:0] sample,
        input logic [VOL_W-1:0]           vol
    );
        int gain;
        int product;
        gain = int'(vol & COARSE_MASK);
        if (gain == 0)
            gain = int'(vol & FINE_MASK);
        product = int'(sample) * gain;
        return LEVEL_W'(product / FULL_SCALE);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        level_pair_t want;
        level_pair_t got;
        if (!rst_n)
        begin
            fader_volume = VOL_RESET;
            level_queue.delete();
        end
        else
        begin
            if (sample_in.valid && sample_in.ready)
            begin
                if (sample_in.audio_paused)
                begin
                    want.left_level  = '0;
                    want.right_level = '0;
                end
                else
                begin
                    want.left_level  = scaled_level(sample_in.left_sample, fader_volume);
                    want.right_level = scaled_level(sample_in.right_sample, fader_volume);
                    if (fader_volume < sample_in.target_volume)
                        fader_volume = fader_volume + 1'b1;
                    else if (fader_volume > sample_in.target_volume)
                        fader_volume = fader_volume - 1'b1;
                end
                level_queue.push_back(want);
            end
            if (level_out.valid && level_out.ready)
            begin
                got.left_level  = level_out.left_level;
                got.right_level = level_out.right_level;
                if (level_queue.size() == 0)
                begin
                    $error("level_out: unexpected transaction, left %0d right %0d",
                           got.left_level, got.right_level);
                    mismatches++;
                end
                else
                begin
                    want = level_queue.pop_front();
                    if (got.left_level !== want.left_level)
                    begin
                        $error("left_level: expected %0d, got %0d",
                               want.left_level, got.left_level);
                        mismatches++;
                    end
                    if (got.right_level !== want.right_level)
                    begin
                        $error("right_level: expected %0d, got %0d",
                               want.right_level, got.right_level);
                        mismatches++;
                    end
                end
            end
        end
        queued = level_queue.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb - testbench top for cd_audio_volume_fader
// Drives sample transactions with random gaps and output back-pressure,
// walks the volume ramp down through the fine gains to zero, and reports
// the verdict from the level checker.
// ============================================================================
module tb;
    import cdvf_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    cdvf_in_if  sample_in();
    cdvf_out_if level_out();

    int fail_count;
    int pending;

    // Volume the block should hold, tracked only to steer the ramp phases
    logic [VOL_W-1:0] vol_track = VOL_RESET;
    int               sent_count = 0;
    int               recv_count = 0;

    cd_audio_volume_fader dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .level_out (level_out)
    );

    level_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .level_out  (level_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Full-range random sample, with the extremes and near-zero values
    // showing up often enough to hit the largest products.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            4:       return 16'sd1;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // One sample transaction. Gaps come in phases: every 150 transactions the
    // sender flips between back-to-back and random idle cycles.
    task automatic send_fade(
        input logic signed [SAMPLE_W-1:0] left,
        input logic signed [SAMPLE_W-1:0] right,
        input logic [VOL_W-1:0]           target,
        input logic                       paused
    );
        int gap;
        gap = ((sent_count / 150) % 2 == 1) ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            sample_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_in.valid         <= 1'b1;
        sample_in.left_sample   <= left;
        sample_in.right_sample  <= right;
        sample_in.target_volume <= target;
        sample_in.audio_paused  <= paused;
        @(posedge clk);
        while (!sample_in.ready)
            @(posedge clk);
        sent_count++;
        // Volume only ramps while playing
        if (!paused)
        begin
            if (vol_track < target)
                vol_track = vol_track + 1'b1;
            else if (vol_track > target)
                vol_track = vol_track - 1'b1;
        end
    endtask

    // Random transaction whose target is chosen by the caller
    task automatic send_random(input logic [VOL_W-1:0] target, input int pause_odds);
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        left  = pick_sample();
        right = pick_sample();
        // Coarse gain at its top (2044): push full-scale samples through
        if (vol_track[10:2] == '1 && $urandom_range(0, 1) == 1)
        begin
            left  = 16'sh8000;
            right = 16'sh7fff;
        end
        send_fade(left, right, target, $urandom_range(1, pause_odds) == 1);
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls in phases, plus two long hold-offs so the
    // pipeline fills and sample_in.ready drops while the sender keeps offering.
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        level_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (recv_count == 100 || recv_count == 1000)
                stall = 60;
            else if ((recv_count / 200) % 2 == 0)
                stall = $urandom_range(0, 6);
            else
                stall = 0;
            if (stall > 0)
            begin
                level_out.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            level_out.ready <= 1'b1;
            @(posedge clk);
            while (!level_out.valid)
                @(posedge clk);
            recv_count++;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int n;
        rst_n                   <= 1'b0;
        sample_in.valid         <= 1'b0;
        sample_in.left_sample   <= '0;
        sample_in.right_sample  <= '0;
        sample_in.target_volume <= '0;
        sample_in.audio_paused  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full scale after reset, target equal to volume, so the
        // levels are the samples themselves and the volume holds.
        send_fade(16'sh7fff, 16'sh8000, 12'd1024, 1'b0);
        send_fade(16'sh8000, 16'sh7fff, 12'd1024, 1'b0);
        send_fade(16'sh0000, 16'sh0000, 12'd1024, 1'b0);
        send_fade(-16'sd1,   16'sd1,    12'd1024, 1'b0);
        send_fade(16'sd1,    -16'sd1,   12'd1024, 1'b0);
        send_fade(16'sh5555, 16'shaaaa, 12'd1024, 1'b0);
        // Paused: zero levels, volume held whatever the target
        send_fade(16'sh7fff, 16'sh8000, 12'hfff,  1'b1);
        send_fade(16'sh8000, 16'sh7fff, 12'h000,  1'b1);
        send_fade(16'shaaaa, 16'sh5555, 12'd2048, 1'b1);
        // Single steps up and down around full scale
        send_fade(16'sh7fff, 16'sh8000, 12'hfff,  1'b0);
        send_fade(16'sh7fff, 16'sh8000, 12'd2048, 1'b0);
        send_fade(16'sh8000, 16'sh7fff, 12'h000,  1'b0);
        send_fade(16'sh8000, 16'sh7fff, 12'h000,  1'b0);
        send_fade(16'sh8000, 16'sh7fff, 12'h000,  1'b0);
        send_fade(16'sh7fff, -16'sd1,   12'h555,  1'b0);
        send_fade(-16'sd1,   16'sh7fff, 12'haaa,  1'b0);
        send_fade(16'sh1234, 16'shedcb, 12'd1024, 1'b0);
        send_fade(16'sh8000, 16'sh8000, 12'd1024, 1'b0);
        send_fade(16'sh7fff, 16'sh7fff, 12'd1024, 1'b1);
        send_fade(16'sh0001, 16'sh8001, 12'd1024, 1'b0);

        // Ramp all the way down through the fine gains to zero
        while (vol_track != '0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_random(vol_track, 10);
            else if ($urandom_range(0, 1) == 0)
                send_random('0, 10);
            else
                send_random(VOL_W'($urandom_range(0, int'(vol_track) - 1)), 10);
        end

        // Parked at zero with a zero target
        for (n = 0; n < 30; n++)
            send_random('0, 6);

        // Creep back up through the fine steps, then wander
        for (n = 0; n < 12; n++)
            send_random(12'd8, 8);
        for (n = 0; n < 230; n++)
            send_random(VOL_W'($urandom()), 6);

        sample_in.valid <= 1'b0;

        // Drain: everything predicted has to come out, then the bench keeps
        // watching to catch anything extra.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog
    initial
    begin
        #800000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
hdl/cdvf_pkg.sv
hdl/cdvf_in_if.sv
hdl/cdvf_out_if.sv
hdl/cdvf_lane.sv
hdl/cdvf_merge.sv
hdl/cd_audio_volume_fader.sv
verif/level_checker.sv
verif/tb.sv
